/* rtl/gafm_pkg.sv */
// ----------------------------------------------------------------------------
// gafm_pkg: shared definitions for the acknowledge frame matcher
// Frame constants, widths, register indexes and the hunt phase type.
// ----------------------------------------------------------------------------
package gafm_pkg;

    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W      = 3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
    localparam logic [BYTE_W-1:0] ACK_CLASS   = 8'h05;
    localparam logic [BYTE_W-1:0] ACK_ID      = 8'h01;
    localparam logic [BYTE_W-1:0] LEN_LOW     = 8'h02;
    localparam logic [BYTE_W-1:0] LEN_HIGH    = 8'h00;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1200;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASS = 2'd0,
        CFG_ID    = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    // Body byte positions.
    typedef enum logic [IDX_W-1:0] {
        POS_CLASS   = 3'd0,
        POS_ID      = 3'd1,
        POS_LEN_LO  = 3'd2,
        POS_LEN_HI  = 3'd3,
        POS_EXP_CLS = 3'd4,
        POS_EXP_ID  = 3'd5,
        POS_CK_A    = 3'd6,
        POS_CK_B    = 3'd7
    } t_pos;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_SYNC2 = 3'b010,
        PH_BODY  = 3'b100
    } t_phase;

    localparam logic STATUS_ACK  = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

/* rtl/gnss_ack_frame_matcher.sv */
// ----------------------------------------------------------------------------
// gnss_ack_frame_matcher: acknowledge frame matcher for a GNSS serial link
// Scans received bytes for an acknowledge frame with Fletcher checksum and
// reports a match, or a failure once the attempt count reaches the limit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Transfer when
//  s_axis    in         tdata[7:0] = rx_byte             s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata[0] = ack_status, rest 0    m_axis_tvalid & m_axis_tready
//  cfg       in         index 0 class, 1 id, 2 limit     i_cfg_valid & o_cfg_ready
//
// One received byte is taken per cycle while the input is ready. Its whole
// effect on the scan state and the checksum is computed in the cycle of the
// transfer; a status it causes sits in the output register on the next cycle.
// The input stays ready while the output register is empty or being drained,
// so a stalled consumer holds the input back only while a status waits.
// Reset (i_rst_n low, synchronous) returns the scan to hunting for the first
// sync byte, clears the counter and loads the default register values.
// ----------------------------------------------------------------------------
module gnss_ack_frame_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Received bytes: [7:0] rx_byte.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gafm_pkg::BYTE_W-1:0]         s_axis_tdata,
    // Results: [0] ack_status, [7:1] zero.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [gafm_pkg::BYTE_W-1:0]         m_axis_tdata,
    // Register writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gafm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gafm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gafm_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0]  r_exp_class;
    logic [BYTE_W-1:0]  r_exp_id;
    logic [LIMIT_W-1:0] r_limit;

    // Scan state.
    t_phase             r_phase,    n_phase;
    logic [IDX_W-1:0]   r_index,    n_index;
    logic [BYTE_W-1:0]  r_sum_a,    n_sum_a;
    logic [BYTE_W-1:0]  r_sum_b,    n_sum_b;
    logic               r_mismatch, n_mismatch;
    logic [LIMIT_W-1:0] r_count,    n_count;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;

    logic               in_xfer;
    logic               emit;
    logic               emit_status;
    logic [BYTE_W-1:0]  rx;
    logic [BYTE_W-1:0]  exp_byte;
    logic [BYTE_W-1:0]  sum_a_upd;
    logic [LIMIT_W-1:0] count_inc;
    logic               limit_hit;
    logic               body_bad;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(BYTE_W-1){1'b0}}, r_out_status};

    // A failed attempt bumps the counter; reaching the limit reports failure.
    assign count_inc = r_count + LIMIT_W'(1);
    assign limit_hit = (count_inc >= r_limit);
    assign sum_a_upd = r_sum_a + rx;

    // Byte the current body position must carry.
    always_comb begin
        case (t_pos'(r_index))
            POS_CLASS:   exp_byte = ACK_CLASS;
            POS_ID:      exp_byte = ACK_ID;
            POS_LEN_LO:  exp_byte = LEN_LOW;
            POS_LEN_HI:  exp_byte = LEN_HIGH;
            POS_EXP_CLS: exp_byte = r_exp_class;
            POS_EXP_ID:  exp_byte = r_exp_id;
            POS_CK_A:    exp_byte = r_sum_a;
            POS_CK_B:    exp_byte = r_sum_b;
            default:     exp_byte = r_sum_b;
        endcase
    end

    assign body_bad = r_mismatch || (rx != exp_byte);

    always_comb begin
        n_phase     = r_phase;
        n_index     = r_index;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_mismatch  = r_mismatch;
        n_count     = r_count;
        emit        = 1'b0;
        emit_status = STATUS_FAIL;

        if (in_xfer) begin
            case (r_phase)
                PH_SYNC2: begin
                    if (rx == SYNC_SECOND) begin
                        n_phase    = PH_BODY;
                        n_index    = '0;
                        n_sum_a    = '0;
                        n_sum_b    = '0;
                        n_mismatch = 1'b0;
                    end else begin
                        // The wrong byte is consumed, not rescanned as sync 1.
                        n_phase = PH_HUNT;
                        emit    = limit_hit;
                        n_count = limit_hit ? '0 : count_inc;
                    end
                end
                PH_BODY: begin
                    n_mismatch = body_bad;
                    if (r_index < IDX_W'(POS_CK_A)) begin
                        n_sum_a = sum_a_upd;
                        n_sum_b = r_sum_b + sum_a_upd;
                    end
                    if (r_index != IDX_W'(POS_CK_B)) begin
                        n_index = r_index + IDX_W'(1);
                    end else begin
                        n_phase = PH_HUNT;
                        n_index = '0;
                        if (!body_bad) begin
                            n_count     = '0;
                            emit        = 1'b1;
                            emit_status = STATUS_ACK;
                        end else begin
                            emit    = limit_hit;
                            n_count = limit_hit ? '0 : count_inc;
                        end
                    end
                end
                default: begin
                    // Hunting for the first sync byte.
                    if (rx == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_HUNT;
                        emit    = limit_hit;
                        n_count = limit_hit ? '0 : count_inc;
                    end
                end
            endcase
        end
    end

    // The output register drains on a transfer and refills from a new byte.
    always_comb begin
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = emit_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_class <= '0;
            r_exp_id    <= '0;
            r_limit     <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLASS: r_exp_class <= i_cfg_data[BYTE_W-1:0];
                CFG_ID:    r_exp_id    <= i_cfg_data[BYTE_W-1:0];
                CFG_LIMIT: r_limit     <= i_cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_index     <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_mismatch  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_index     <= n_index;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_mismatch  <= n_mismatch;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
    end

endmodule

/* rtl/gafm_checker.sv */
// ----------------------------------------------------------------------------
// gafm_checker: port-level checks for the acknowledge frame matcher
// Watches the stream ports over time and reports violations.
// ----------------------------------------------------------------------------
module gafm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [gafm_pkg::BYTE_W-1:0] m_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready
);
    import gafm_pkg::*;

    // A waiting status must not change while the consumer stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("status changed while stalled");

    // With the output register empty the byte input must be open.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Only the status bit may be set in a result.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[BYTE_W-1:1] == '0))
        else $error("nonzero padding in result");

    // A new status only ever follows a byte transfer.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("status without received byte");

endmodule

bind gnss_ack_frame_matcher gafm_checker u_gafm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
